[hw/rtl/itoa_pkg.sv]
package itoa_pkg;

  localparam int unsigned ValueWidth = 32;
  // decimal digits in the largest magnitude, 2**(ValueWidth-1)
  localparam int unsigned DigitsMax  = 10;
  localparam int unsigned DigitIdxW  = $clog2(DigitsMax + 1);
  localparam int unsigned CountW     = 4;

  // q = (m * DivRecip) >> DivShift equals m / 10 for every 32-bit m
  localparam logic [ValueWidth-1:0] DivRecip = 32'hCCCC_CCCD;
  localparam int unsigned           DivShift = 35;
  localparam logic [3:0]            Radix    = 4'd10;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } entry_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackConv,
    BackEmit
  } back_state_e;

endpackage

[hw/rtl/itoa_front.sv]
module itoa_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [itoa_pkg::ValueWidth-1:0]     in_value_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output itoa_pkg::entry_t                    push_entry_o
);

  logic             valid_q, valid_d;
  itoa_pkg::entry_t entry_q, entry_d;
  logic             load;

  assign in_ready_o = !valid_q || push_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // sign and magnitude; the most negative value negates to itself as unsigned
  always_comb begin
    entry_d.neg = in_value_i[itoa_pkg::ValueWidth-1];
    entry_d.mag = entry_d.neg ? (~in_value_i + 1'b1) : in_value_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

[hw/rtl/itoa_fifo.sv]
module itoa_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  itoa_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output itoa_pkg::entry_t pop_entry_o
);

  itoa_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[hw/rtl/itoa_back.sv]
module itoa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  itoa_pkg::entry_t pop_entry_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic [itoa_pkg::CountW-1:0] out_total_o,
  output logic             out_last_o
);

  localparam int unsigned W  = itoa_pkg::ValueWidth;
  localparam int unsigned IW = itoa_pkg::DigitIdxW;
  localparam int unsigned CW = itoa_pkg::CountW;

  itoa_pkg::back_state_e state_q, state_d;

  logic [W-1:0]  mag_q, mag_d;
  logic          neg_q, neg_d;
  logic          sign_pend_q, sign_pend_d;
  logic [IW-1:0] nd_q, nd_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] total_q, total_d;
  logic [3:0]    digit_q [itoa_pkg::DigitsMax];

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;
  logic [CW-1:0] out_total_q, out_total_d;

  logic [2*W-1:0] prod;
  logic [W-1:0]   quot;
  logic [3:0]     digit;
  logic [3:0]     qten;
  logic           out_free;
  logic           digit_we;

  // one digit per cycle: quotient by reciprocal, remainder from the low nibble
  assign prod  = (2*W)'(mag_q) * (2*W)'(itoa_pkg::DivRecip);
  assign quot  = W'(prod >> itoa_pkg::DivShift);
  assign qten  = 4'(quot[3:0] * itoa_pkg::Radix);
  assign digit = mag_q[3:0] - qten;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::BackIdle: begin
        if (pop_valid_i) begin
          state_d = itoa_pkg::BackConv;
        end
      end
      itoa_pkg::BackConv: begin
        if (quot == '0) begin
          state_d = itoa_pkg::BackEmit;
        end
      end
      itoa_pkg::BackEmit: begin
        if (out_free && !sign_pend_q && idx_q == '0) begin
          state_d = itoa_pkg::BackIdle;
        end
      end
      default: state_d = itoa_pkg::BackIdle;
    endcase
  end

  always_comb begin
    pop_ready_o = 1'b0;
    digit_we    = 1'b0;
    mag_d       = mag_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    nd_d        = nd_q;
    idx_d       = idx_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_total_d = out_total_q;
    case (state_q)
      itoa_pkg::BackIdle: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          mag_d = pop_entry_i.mag;
          neg_d = pop_entry_i.neg;
          nd_d  = '0;
        end
      end
      itoa_pkg::BackConv: begin
        digit_we = 1'b1;
        mag_d    = quot;
        nd_d     = nd_q + 1'b1;
        if (quot == '0) begin
          idx_d       = nd_q;
          sign_pend_d = neg_q;
          total_d     = CW'(nd_q) + CW'(1) + CW'(neg_q);
        end
      end
      itoa_pkg::BackEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          if (sign_pend_q) begin
            out_char_d  = itoa_pkg::CharMinus;
            out_last_d  = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            out_char_d = itoa_pkg::CharZero + 8'(digit_q[idx_q]);
            out_last_d = (idx_q == '0);
            if (idx_q != '0) begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::BackIdle;
      out_valid_q <= 1'b0;
      sign_pend_q <= 1'b0;
      nd_q        <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sign_pend_q <= sign_pend_d;
      nd_q        <= nd_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    total_q     <= total_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_total_q <= out_total_d;
    if (digit_we) begin
      digit_q[nd_q] <= digit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_total_o = out_total_q;
  assign out_last_o  = out_last_q;

endmodule

[hw/rtl/signed_int_to_decimal_ascii_core.sv]
// order: an accepted value passes through the front register and the queue, then the
// back end computes one decimal digit per cycle and then loads each character into
// the output register
// overlap: the front register and queue take new values while the back end converts,
// but the back end starts the next value only after loading the last character
// reset: rst_ni asynchronous active low empties the front register, queue and output register
module signed_int_to_decimal_ascii_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [itoa_pkg::InDataW-1:0]  s_axis_tdata_i,  // [31:0] value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] character, [11:8] total_chars, [15:12] zero
  output logic [itoa_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  logic             push_valid, push_ready;
  itoa_pkg::entry_t push_entry;
  logic             pop_valid, pop_ready;
  itoa_pkg::entry_t pop_entry;
  logic [7:0]       out_char;
  logic [itoa_pkg::CountW-1:0] out_total;

  itoa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_value_i   (s_axis_tdata_i[itoa_pkg::ValueWidth-1:0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  itoa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_total_o (out_total),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_total, out_char};

endmodule
